>>> rtl/fps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg: shared types and constants
// Widths, command codes and the sequencer state type for the permutation
// sign core.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int IMG_W  = 6;    // image / site field width
    localparam int SEEN_W = 64;   // one bit per possible image value
    localparam int OCC_W  = 64;   // occupancy mask width
    localparam int NS_W   = 7;    // num_sites register width
    localparam int APB_AW = 3;    // byte address, one 32-bit register
    localparam int APB_DW = 32;

    localparam logic [NS_W-1:0] NUM_SITES_RST = 7'd64;

    // register word index (paddr[2])
    localparam logic REG_NUM_SITES = 1'b0;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST,
        ST_DONE
    } t_state;

    // control to the parity unit
    typedef struct packed {
        logic clear;
        logic step;
    } t_unit_ctl;

    // mask of image values 0..v inclusive
    function automatic logic [SEEN_W-1:0] mask_up_to(input logic [IMG_W-1:0] v);
        logic [IMG_W-1:0] sh;
        begin
            sh = ~v;   // 63 - v
            mask_up_to = {SEEN_W{1'b1}} >> sh;
        end
    endfunction

endpackage

>>> rtl/fps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data appears in the next cycle.
// ----------------------------------------------------------------------------
module fps_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fps_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_unit: inversion parity accumulator
// Per occupied site: toggles parity by (seen count - seen images <= v),
// then marks image v as seen.
// ----------------------------------------------------------------------------
module fps_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fps_pkg::t_unit_ctl      i_ctl,
    input  logic [fps_pkg::IMG_W-1:0] i_image,
    output logic                    o_odd
);
    import fps_pkg::*;

    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_cnt_par, n_cnt_par;   // parity of occupied sites seen
    logic              r_odd, n_odd;
    logic              w_le_par;

    // only the parity of the count matters: an XOR tree replaces popcount
    assign w_le_par = ^(r_seen & mask_up_to(i_image));

    always_comb begin
        n_seen    = r_seen;
        n_cnt_par = r_cnt_par;
        n_odd     = r_odd;
        if (i_ctl.clear) begin
            n_seen    = '0;
            n_cnt_par = 1'b0;
            n_odd     = 1'b0;
        end else if (i_ctl.step) begin
            n_odd     = r_odd ^ r_cnt_par ^ w_le_par;
            n_seen    = r_seen | (SEEN_W'(1) << i_image);
            n_cnt_par = ~r_cnt_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_par <= 1'b0;
            r_odd     <= 1'b0;
        end else begin
            r_cnt_par <= n_cnt_par;
            r_odd     <= n_odd;
        end
        r_seen <= n_seen;
    end

    assign o_odd = r_odd;

endmodule

>>> rtl/fermion_permutation_sign_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fermion_permutation_sign_core: fermionic sign of a site permutation
// Holds a site -> image table; queries return the parity of the inversion
// count of the images of the occupied sites.
// ----------------------------------------------------------------------------
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+---------------
//  command   | i_cmd, i_entry_site, i_entry_image, i_occupancy | start & !busy
//  result    | o_sign_odd                                      | o_valid strobe
//  config    | psel, penable, pwrite, paddr, pwdata, prdata    | APB, pready=1
//
//  Write beat (cmd 0): table written at the accepting edge, busy stays low.
//  Query beat (cmd 1): one table read per cycle through the RAM port;
//    the result strobe follows the reads of L = min(num_sites, MAX_SITES)
//    sites, and busy is high until the strobe cycle ends.
//  Reset: synchronous, active low; clears the sequencer and sets num_sites
//    to 64. Table contents are undefined until written.
//  The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module fermion_permutation_sign_core #(
    parameter int MAX_SITES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [fps_pkg::IMG_W-1:0]     i_entry_site,
    input  logic [fps_pkg::IMG_W-1:0]     i_entry_image,
    input  logic [fps_pkg::OCC_W-1:0]     i_occupancy,
    // result
    output logic                          o_valid,
    output logic                          o_sign_odd,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fps_pkg::APB_AW-1:0]    paddr,
    input  logic [fps_pkg::APB_DW-1:0]    pwdata,
    output logic [fps_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import fps_pkg::*;

    localparam int AW = $clog2(MAX_SITES);       // table address
    localparam int CW = $clog2(MAX_SITES + 1);   // site counter, holds MAX_SITES

    // ---------------- config register ----------------
    logic [NS_W-1:0] r_num_sites;
    logic            w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_NUM_SITES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sites <= NUM_SITES_RST;
        end else if (w_cfg_wr) begin
            r_num_sites <= pwdata[NS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NUM_SITES) ? APB_DW'(r_num_sites) : '0;

    // effective site count, saturated at MAX_SITES
    logic [NS_W-1:0] w_lim_full;
    logic [CW-1:0]   w_limit;

    assign w_lim_full = (r_num_sites > NS_W'(MAX_SITES)) ? NS_W'(MAX_SITES) : r_num_sites;
    assign w_limit    = w_lim_full[CW-1:0];

    // ---------------- sequencer ----------------
    t_state          r_state, n_state;
    logic [CW-1:0]   r_site, n_site;
    logic [OCC_W-1:0] r_occ, n_occ;      // shifts right, bit 0 is current site
    logic            r_rd_vld, n_rd_vld; // RAM data valid next cycle
    logic            r_rd_occ, n_rd_occ; // that site is occupied
    logic            w_accept;
    logic            w_we;
    t_unit_ctl       w_ctl;
    logic [IMG_W-1:0] w_image;
    logic            w_odd;

    assign w_accept = start & ~busy;
    // a write to a site past the table is dropped
    assign w_we     = w_accept & (i_cmd == CMD_WRITE)
                    & ({1'b0, i_entry_site} < (IMG_W+1)'(MAX_SITES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
        r_site   <= n_site;
        r_occ    <= n_occ;
        r_rd_occ <= n_rd_occ;
    end

    always_comb begin
        n_state   = r_state;
        n_site    = r_site;
        n_occ     = r_occ;
        n_rd_vld  = 1'b0;
        n_rd_occ  = 1'b0;
        w_ctl     = '0;
        busy      = 1'b1;
        o_valid   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (w_accept && (i_cmd == CMD_QUERY)) begin
                    n_state   = ST_RUN;
                    n_site    = '0;
                    n_occ     = i_occupancy;
                    w_ctl.clear = 1'b1;
                end
            end
            ST_RUN: begin
                // finish the previous site's read while issuing the next
                w_ctl.step = r_rd_vld & r_rd_occ;
                if (r_site < w_limit) begin
                    n_rd_vld = 1'b1;
                    n_rd_occ = r_occ[0];
                    n_occ    = r_occ >> 1;
                    n_site   = r_site + CW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LAST: begin
                // not entered; kept for decode completeness
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_sign_odd = w_odd;

    // ---------------- table ----------------
    fps_ram #(
        .WIDTH (IMG_W),
        .DEPTH (MAX_SITES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_entry_site[AW-1:0]),
        .i_wdata (i_entry_image),
        .i_raddr (r_site[AW-1:0]),
        .o_rdata (w_image)
    );

    // ---------------- parity unit ----------------
    fps_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_image (w_image),
        .o_odd   (w_odd)
    );

endmodule
